/* sv/oft_pkg.sv */
// Shared types and constants for the originator freshness table.
`default_nettype none

package oft_pkg;

    // Fixed field widths of the channels and of the configuration port.
    localparam int ADDR_W     = 48;
    localparam int SEQN_W     = 8;
    localparam int KIND_W     = 2;
    localparam int OUTC_W     = 3;
    localparam int PURGE_W    = 7;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Operation codes of an input word.
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Packet kinds.
    localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLIENT = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ROLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = '0;
    localparam logic              OWN_ROLE_RST    = 1'b1;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST     = 16'd60;

    // Broadcast target address.
    localparam logic [ADDR_W-1:0] ADDR_BCAST = '1;

    typedef enum logic [OUTC_W-1:0] {
        OUT_IGNORED = 3'd0,
        OUT_DUP     = 3'd1,
        OUT_STALE   = 3'd2,
        OUT_NEW     = 3'd3,
        OUT_FULL    = 3'd4,
        OUT_TICK    = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Verdict of the shared compare unit on one stored entry.
    typedef struct packed {
        logic hit;
        logic free;
        logic seq_eq;
        logic seq_lt;
        logic expired;
    } t_eval;

endpackage

`default_nettype wire

/* sv/oft_in_if.sv */
// Input channel of the originator freshness table: one packet or tick word.
`default_nettype none

interface oft_in_if import oft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] origin_address;
    logic [ADDR_W-1:0] sender_address;
    logic [ADDR_W-1:0] target_address;
    logic [SEQN_W-1:0] sequence_number;
    logic [KIND_W-1:0] packet_kind;

    modport source (
        output valid, opcode, origin_address, sender_address, target_address,
               sequence_number, packet_kind,
        input  ready
    );

    modport sink (
        input  valid, opcode, origin_address, sender_address, target_address,
               sequence_number, packet_kind,
        output ready
    );
endinterface

`default_nettype wire

/* sv/oft_out_if.sv */
// Output channel of the originator freshness table: one result word.
`default_nettype none

interface oft_out_if import oft_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OUTC_W-1:0]  outcome;
    logic               forward;
    logic               upgrade_to_sync;
    logic [PURGE_W-1:0] purged_count;

    modport source (
        output valid, outcome, forward, upgrade_to_sync, purged_count,
        input  ready
    );

    modport sink (
        input  valid, outcome, forward, upgrade_to_sync, purged_count,
        output ready
    );
endinterface

`default_nettype wire

/* sv/oft_mem.sv */
// Entry memory: one write port and one registered read port.
`default_nettype none

module oft_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 89
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/oft_eval.sv */
// Shared compare unit: judges one stored entry against the word in work.
`default_nettype none

module oft_eval import oft_pkg::*; #(
    parameter int SEQ_BITS  = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_valid,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic [SEQ_BITS-1:0]  i_sequence,
    input  wire logic [TIME_BITS-1:0] i_time,
    input  wire logic [ADDR_W-1:0]    i_key,
    input  wire logic [SEQ_BITS-1:0]  i_seq,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic [TMO_W-1:0]     i_timeout,
    output      t_eval                o_eval
);

    logic [TIME_BITS-1:0] limit;
    logic [TIME_BITS-1:0] diff;

    always_comb begin
        // Wrap-aware age check: now is after the limit when the modular
        // difference is nonzero and its top bit is clear.
        limit          = i_time + TIME_BITS'(i_timeout);
        diff           = i_now - limit;
        o_eval.hit     = i_valid && (i_address == i_key);
        o_eval.free    = !i_valid;
        o_eval.seq_eq  = (i_seq == i_sequence);
        o_eval.seq_lt  = (i_seq < i_sequence);
        o_eval.expired = i_valid && (diff != '0) && !diff[TIME_BITS-1];
    end

endmodule

`default_nettype wire

/* sv/originator_freshness_table_top.sv */
// Top level of the originator freshness table: sequencer, registers and result stage.
`default_nettype none

// The table keeps up to ENTRIES originators in one single-port-write, registered-read
// memory, and a small sequencer walks it one entry per cycle through a single shared
// compare unit. A received packet that is not filtered out (own origin or sender,
// unknown kind, client update to broadcast) scans from entry 0 until it finds its
// originator or reaches the last entry; a filtered packet skips the scan. A tick
// always scans every entry, purging expired entries as it goes. In each case the
// result word is registered at the clock edge at which input ready rises again;
// both wait while the output register still holds an unread result. After reset the
// block runs a clearing pass that marks every entry free; input ready stays low
// during it, while configuration writes are taken at any time. Input ready is high
// only while the sequencer is idle, and a finished result sits in an output register,
// so the next word can be taken while the previous result waits to be read.
// Configuration must only be written while the block is idle.

module originator_freshness_table_top import oft_pkg::*; #(
    parameter int ENTRIES   = 64,
    parameter int SEQ_BITS  = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    oft_in_if.sink                     i_in,
    oft_out_if.source                  o_out
);

    localparam int IW = $clog2(ENTRIES);
    localparam int EW = 1 + ADDR_W + SEQ_BITS + TIME_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Bit positions of the fields within one memory entry.
    localparam int TIME_LO = 0;
    localparam int SEQ_LO  = TIME_BITS;
    localparam int ADDR_LO = TIME_BITS + SEQ_BITS;
    localparam int VLD_POS = EW - 1;

    // Configuration registers.
    logic [ADDR_W-1:0] r_own_address;
    logic              r_own_role;
    logic [TMO_W-1:0]  r_timeout;

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    logic [IW-1:0]        r_idx;
    logic                 r_issue_done;
    logic                 r_rd_pend;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic [PURGE_W-1:0]   r_count;
    logic [TIME_BITS-1:0] r_time;

    // Word in work.
    logic                 r_op;
    logic [ADDR_W-1:0]    r_origin;
    logic [SEQ_BITS-1:0]  r_seq;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_tgt_own;
    t_outcome             r_res;

    // Output stage.
    logic                 r_out_valid;
    logic [OUTC_W-1:0]    r_out_outcome;
    logic                 r_out_forward;
    logic                 r_out_upgrade;
    logic [PURGE_W-1:0]   r_out_purged;

    // Sequencer outputs.
    logic                 rd_en;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic                 wr_valid;
    logic                 finish;
    t_outcome             fin_outcome;
    logic                 purge_hit;

    logic                 in_accept;
    logic                 ignore_pkt;
    logic                 out_free;
    logic                 res_forward;
    logic                 res_upgrade;

    logic [EW-1:0]        rd_data;
    logic [EW-1:0]        wr_data;
    t_eval                ev;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    // Packets that never touch the table.
    always_comb begin
        ignore_pkt = (i_in.origin_address == r_own_address)
                  || (i_in.sender_address == r_own_address)
                  || ((i_in.packet_kind != KIND_SYNC) && (i_in.packet_kind != KIND_CLIENT))
                  || ((i_in.packet_kind == KIND_CLIENT) && (i_in.target_address == ADDR_BCAST));
    end

    oft_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    oft_eval #(
        .SEQ_BITS  (SEQ_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_valid    (rd_data[VLD_POS]),
        .i_address  (rd_data[ADDR_LO +: ADDR_W]),
        .i_sequence (rd_data[SEQ_LO +: SEQ_BITS]),
        .i_time     (rd_data[TIME_LO +: TIME_BITS]),
        .i_key      (r_origin),
        .i_seq      (r_seq),
        .i_now      (r_time),
        .i_timeout  (r_timeout),
        .o_eval     (ev)
    );

    assign wr_data = {wr_valid, r_origin, r_seq, r_time};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in.opcode == OP_PACKET && ignore_pkt) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory access and the verdict at the end of a scan.
    always_comb begin
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = r_idx;
        wr_valid    = 1'b0;
        finish      = 1'b0;
        fin_outcome = OUT_IGNORED;
        purge_hit   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_SCAN: begin
                rd_en = !r_issue_done;
                if (r_rd_pend) begin
                    if (r_op == OP_TICK) begin
                        if (ev.expired) begin
                            wr_en     = 1'b1;
                            wr_idx    = r_rd_idx;
                            purge_hit = 1'b1;
                        end
                        if (r_rd_idx == LAST_IDX) begin
                            finish      = 1'b1;
                            fin_outcome = OUT_TICK;
                        end
                    end else if (ev.hit) begin
                        finish = 1'b1;
                        priority if (ev.seq_eq) begin
                            fin_outcome = OUT_DUP;
                        end else if (ev.seq_lt) begin
                            fin_outcome = OUT_STALE;
                        end else begin
                            // Newer sequence number replaces the entry in place.
                            fin_outcome = OUT_NEW;
                            wr_en       = 1'b1;
                            wr_idx      = r_rd_idx;
                            wr_valid    = 1'b1;
                        end
                    end else if (r_rd_idx == LAST_IDX) begin
                        finish = 1'b1;
                        if (r_free_found || ev.free) begin
                            fin_outcome = OUT_NEW;
                            wr_en       = 1'b1;
                            wr_idx      = r_free_found ? r_free_idx : r_rd_idx;
                            wr_valid    = 1'b1;
                        end else begin
                            fin_outcome = OUT_FULL;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Forwarding rules for the finished packet.
    always_comb begin
        res_forward = 1'b0;
        res_upgrade = 1'b0;
        if (r_op == OP_PACKET && r_res != OUT_IGNORED) begin
            if (r_kind == KIND_SYNC) begin
                res_forward = (r_res == OUT_NEW) && r_own_role;
            end else if (r_res != OUT_STALE && r_res != OUT_FULL) begin
                if (r_own_role && r_tgt_own && r_res == OUT_NEW) begin
                    res_forward = 1'b1;
                    res_upgrade = 1'b1;
                end else begin
                    res_forward = !r_tgt_own;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDRESS_RST;
            r_own_role    <= OWN_ROLE_RST;
            r_timeout     <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OWN_ADDRESS:   r_own_address <= i_cfg_data[ADDR_W-1:0];
                REG_OWN_ROLE:      r_own_role    <= i_cfg_data[0];
                REG_TIMEOUT_TICKS: r_timeout     <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_time       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_en;

            if (r_state == ST_CLEAR) begin
                r_idx <= r_idx + 1'b1;
            end else if (in_accept) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end

            if (in_accept) begin
                r_issue_done <= 1'b0;
            end else if (rd_en && r_idx == LAST_IDX) begin
                r_issue_done <= 1'b1;
            end

            // The lowest free slot seen so far.
            if (in_accept) begin
                r_free_found <= 1'b0;
            end else if (r_state == ST_SCAN && r_rd_pend && ev.free && !r_free_found) begin
                r_free_found <= 1'b1;
            end

            if (in_accept) begin
                r_count <= '0;
            end else if (purge_hit) begin
                r_count <= r_count + 1'b1;
            end

            if (in_accept && i_in.opcode == OP_TICK) begin
                r_time <= r_time + 1'b1;
            end

            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (r_state == ST_SCAN && r_rd_pend && ev.free && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (in_accept) begin
            r_op      <= i_in.opcode;
            r_origin  <= i_in.origin_address;
            r_seq     <= SEQ_BITS'(i_in.sequence_number);
            r_kind    <= i_in.packet_kind;
            r_tgt_own <= (i_in.target_address == r_own_address);
            r_res     <= OUT_IGNORED;
        end else if (finish) begin
            r_res <= fin_outcome;
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_outcome <= r_res;
            r_out_forward <= res_forward;
            r_out_upgrade <= res_upgrade;
            r_out_purged  <= r_count;
        end
    end

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.outcome         = r_out_outcome;
    assign o_out.forward         = r_out_forward;
    assign o_out.upgrade_to_sync = r_out_upgrade;
    assign o_out.purged_count    = r_out_purged;

`ifndef ASSERT_OFF
    // Only a tick reports purged entries.
    a_purge_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.outcome != OUT_TICK) |-> (o_out.purged_count == '0))
        else $error("purged count set on a result that is not a tick");

    // An upgrade is only given to a newly stored, forwarded packet.
    a_upgrade_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.upgrade_to_sync) |-> (o_out.forward && o_out.outcome == OUT_NEW))
        else $error("upgrade without forward of a new entry");

    // The clock advances by exactly one on every accepted tick.
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.opcode == OP_TICK) |=> (r_time == TIME_BITS'($past(r_time) + 1'b1)))
        else $error("time did not advance on a tick");

    // A tick scan only ever clears entries, it never marks one valid.
    a_tick_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && wr_en && wr_valid) |-> (r_op == OP_PACKET))
        else $error("entry stored during a tick scan");

    // A scan only ends on a read that has come back from the memory.
    a_finish_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (r_state == ST_SCAN && r_rd_pend))
        else $error("scan finished without read data");
`endif

endmodule

`default_nettype wire
